[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the spring force block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define SF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define SF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[sv/sf3d_pkg.sv]
// ----------------------------------------------------------------------------
// sf3d_pkg
// Widths, register codes and stage types of the spring force block.
// ----------------------------------------------------------------------------
package sf3d_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int DIFF_W     = POS_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int REM_W      = ROOT_W + 2;
  localparam int STR_W      = ROOT_W + 1;
  localparam int ASTR_W     = ROOT_W;
  localparam int KS_W       = CFG_W + ASTR_W;
  localparam int KS_LO_W    = 32;
  localparam int KS_HI_W    = KS_W - KS_LO_W;
  localparam int PLO_W      = KS_LO_W + DIFF_W;
  localparam int PHI_W      = KS_HI_W + DIFF_W;
  localparam int N_W        = KS_W + DIFF_W;
  localparam int Q_W        = DIFF_W;
  localparam int NHI_W      = N_W - Q_W;
  localparam int DEN_W      = ROOT_W + FRAC_BITS;

  localparam logic [CFG_W-1:0] K_RESET    = 32'd65536;
  localparam logic [CFG_W-1:0] REST_RESET = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRING_CONSTANT = 2'd0,
    REG_REST_LENGTH     = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] ad;
    logic [2:0]             dneg;
  } axes_t;

  typedef struct packed {
    logic              valid;
    logic [SUM_W-1:0]  s;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    axes_t             ax;
  } sqrt_stage_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   nlow;
    logic [Q_W-1:0]   quo;
    logic [DEN_W-1:0] den;
  } div_stage_t;

  typedef struct packed {
    logic       valid;
    logic       zlen;
    logic [2:0] neg;
    logic [2:0] presat;
  } div_side_t;

endpackage

[sv/sf3d_if.sv]
// ----------------------------------------------------------------------------
// sf3d channel interfaces
// Valid/ready channels for position pairs in and force results out.
// ----------------------------------------------------------------------------
interface sf3d_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sf3d_pkg::POS_W-1:0]   pos_x;
  logic signed [sf3d_pkg::POS_W-1:0]   pos_y;
  logic signed [sf3d_pkg::POS_W-1:0]   pos_z;
  logic signed [sf3d_pkg::POS_W-1:0]   other_x;
  logic signed [sf3d_pkg::POS_W-1:0]   other_y;
  logic signed [sf3d_pkg::POS_W-1:0]   other_z;
  modport source (output valid, pos_x, pos_y, pos_z, other_x, other_y, other_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, other_x, other_y, other_z,
                output ready);
endinterface

interface sf3d_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sf3d_pkg::POS_W-1:0]   force_x;
  logic signed [sf3d_pkg::POS_W-1:0]   force_y;
  logic signed [sf3d_pkg::POS_W-1:0]   force_z;
  logic                                saturated;
  modport source (output valid, force_x, force_y, force_z, saturated, input ready);
  modport sink (input valid, force_x, force_y, force_z, saturated, output ready);
endinterface

[sv/sf3d_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// sf3d_sqrt_cell
// One registered step of the digit-by-digit square root: two radicand bits in.
// ----------------------------------------------------------------------------
module sf3d_sqrt_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  sf3d_pkg::sqrt_stage_t a,
  output sf3d_pkg::sqrt_stage_t y
);

  logic [sf3d_pkg::REM_W+1:0] rem_sh;
  logic [sf3d_pkg::REM_W+1:0] trial;
  logic                       fit;
  sf3d_pkg::sqrt_stage_t      nxt;

  always_comb begin
    rem_sh   = {a.rem, a.s[sf3d_pkg::SUM_W-1 -: 2]};
    trial    = {2'b00, a.root, 2'b01};
    fit      = (rem_sh >= trial);
    nxt      = a;
    nxt.s    = {a.s[sf3d_pkg::SUM_W-3:0], 2'b00};
    nxt.rem  = fit ? sf3d_pkg::REM_W'(rem_sh - trial) : sf3d_pkg::REM_W'(rem_sh);
    nxt.root = {a.root[sf3d_pkg::ROOT_W-2:0], fit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y.valid <= 1'b0;
    end else if (en) begin
      y <= nxt;
    end
  end

endmodule

[sv/sf3d_div_cell.sv]
// ----------------------------------------------------------------------------
// sf3d_div_cell
// One registered step of restoring division: one quotient bit out.
// ----------------------------------------------------------------------------
module sf3d_div_cell (
  input  logic                 clk,
  input  logic                 en,
  input  sf3d_pkg::div_stage_t a,
  output sf3d_pkg::div_stage_t y
);

  logic [sf3d_pkg::DEN_W:0] rem_sh;
  logic                     fit;
  sf3d_pkg::div_stage_t     nxt;

  always_comb begin
    rem_sh   = {a.rem, a.nlow[sf3d_pkg::Q_W-1]};
    fit      = (rem_sh >= {1'b0, a.den});
    nxt      = a;
    nxt.rem  = fit ? sf3d_pkg::DEN_W'(rem_sh - {1'b0, a.den})
                   : sf3d_pkg::DEN_W'(rem_sh);
    nxt.nlow = {a.nlow[sf3d_pkg::Q_W-2:0], 1'b0};
    nxt.quo  = {a.quo[sf3d_pkg::Q_W-2:0], fit};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= nxt;
    end
  end

endmodule

[sv/spring_force_3d.sv]
// ----------------------------------------------------------------------------
// spring_force_3d
// Hooke spring force on a particle from its position and the far end's.
// ----------------------------------------------------------------------------
// Each beat on req carries the particle position and the position of the
// particle at the other end of its spring, all signed fixed point. Each beat
// on rsp carries the three force components and a flag that is set when any
// component was clipped to the 32-bit range.
// The block is one pipeline: difference and squares, a row of square root
// cells (one per pair of radicand bits), the stiffness multiply split into
// partial products, then three rows of division cells (one per quotient bit).
// Results leave in order, and one beat can be accepted in every cycle while
// the pipeline advances, so the throughput is one pair per cycle.
// The whole pipeline advances together: it moves whenever the output register
// is empty or being taken, so a result waiting in the output register does not
// stop a new beat entering while the receiver is ready.
// When the receiver stalls, every stage holds and req.ready falls in the same
// cycle.
// Reset clears all stage valid flags and loads both registers with one in
// fixed point. Write the registers only while the pipeline is empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spring_force_3d (
  input  logic                              clk,
  input  logic                              rst,
  sf3d_in_if.sink                           req,
  sf3d_out_if.source                        rsp,
  input  logic                              cfg_we,
  input  logic [sf3d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sf3d_pkg::CFG_W-1:0]        cfg_data
);

  logic [sf3d_pkg::CFG_W-1:0] spring_constant;
  logic [sf3d_pkg::CFG_W-1:0] rest_length;

  // The configuration registers take a write at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      spring_constant <= sf3d_pkg::K_RESET;
      rest_length     <= sf3d_pkg::REST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sf3d_pkg::REG_SPRING_CONSTANT: spring_constant <= cfg_data;
        sf3d_pkg::REG_REST_LENGTH:     rest_length     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: everything moves when the output register can take data.
  logic adv;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // Stage 0: difference vector as sign and magnitude.
  logic signed [sf3d_pkg::POS_W-1:0]  pos   [3];
  logic signed [sf3d_pkg::POS_W-1:0]  oth   [3];
  logic signed [sf3d_pkg::DIFF_W-1:0] diff  [3];
  logic                               s0_valid;
  sf3d_pkg::axes_t                    s0_ax;

  assign pos[0] = req.pos_x;
  assign pos[1] = req.pos_y;
  assign pos[2] = req.pos_z;
  assign oth[0] = req.other_x;
  assign oth[1] = req.other_y;
  assign oth[2] = req.other_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {pos[i][sf3d_pkg::POS_W-1], pos[i]} - {oth[i][sf3d_pkg::POS_W-1], oth[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= req.valid;
      for (int i = 0; i < 3; i++) begin
        s0_ax.dneg[i] <= diff[i][sf3d_pkg::DIFF_W-1];
        s0_ax.ad[i]   <= diff[i][sf3d_pkg::DIFF_W-1] ? sf3d_pkg::DIFF_W'(-diff[i])
                                                     : sf3d_pkg::DIFF_W'(diff[i]);
      end
    end
  end

  // Stage 1: one squarer per axis.
  logic                         s1_valid;
  logic [sf3d_pkg::SQ_W-1:0]    s1_sq [3];
  sf3d_pkg::axes_t              s1_ax;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
      s1_ax    <= s0_ax;
      for (int i = 0; i < 3; i++) begin
        s1_sq[i] <= sf3d_pkg::SQ_W'(s0_ax.ad[i]) * sf3d_pkg::SQ_W'(s0_ax.ad[i]);
      end
    end
  end

  // Stage 2: squared length, loaded into the head of the root row.
  sf3d_pkg::sqrt_stage_t sq_st [sf3d_pkg::ROOT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_st[0].valid <= 1'b0;
    end else if (adv) begin
      sq_st[0].valid <= s1_valid;
      sq_st[0].s     <= sf3d_pkg::SUM_W'(s1_sq[0]) + sf3d_pkg::SUM_W'(s1_sq[1])
                      + sf3d_pkg::SUM_W'(s1_sq[2]);
      sq_st[0].rem   <= '0;
      sq_st[0].root  <= '0;
      sq_st[0].ax    <= s1_ax;
    end
  end

  for (genvar g = 0; g < sf3d_pkg::ROOT_STEPS; g++) begin : g_root
    sf3d_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .a   (sq_st[g]),
      .y   (sq_st[g+1])
    );
  end

  // Stage A: stretch from the rest length, and the divisor len << FRAC_BITS.
  logic [sf3d_pkg::ROOT_W-1:0]        len;
  logic signed [sf3d_pkg::STR_W-1:0]  stretch;
  logic                               sa_valid;
  logic                               sa_sneg;
  logic                               sa_zlen;
  logic [sf3d_pkg::ASTR_W-1:0]        sa_astr;
  logic [sf3d_pkg::DEN_W-1:0]         sa_den;
  sf3d_pkg::axes_t                    sa_ax;

  assign len     = sq_st[sf3d_pkg::ROOT_STEPS].root;
  assign stretch = $signed({1'b0, len})
                 - $signed({{(sf3d_pkg::STR_W-sf3d_pkg::CFG_W){1'b0}}, rest_length});

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (adv) begin
      sa_valid <= sq_st[sf3d_pkg::ROOT_STEPS].valid;
      sa_ax    <= sq_st[sf3d_pkg::ROOT_STEPS].ax;
      sa_sneg  <= stretch[sf3d_pkg::STR_W-1];
      sa_zlen  <= (len == '0);
      sa_astr  <= stretch[sf3d_pkg::STR_W-1] ? sf3d_pkg::ASTR_W'(-stretch)
                                             : sf3d_pkg::ASTR_W'(stretch);
      sa_den   <= {len, {sf3d_pkg::FRAC_BITS{1'b0}}};
    end
  end

  // Stage B: k times the stretch magnitude.
  logic                        sb_valid;
  logic                        sb_sneg;
  logic                        sb_zlen;
  logic [sf3d_pkg::KS_W-1:0]   sb_ks;
  logic [sf3d_pkg::DEN_W-1:0]  sb_den;
  sf3d_pkg::axes_t             sb_ax;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else if (adv) begin
      sb_valid <= sa_valid;
      sb_sneg  <= sa_sneg;
      sb_zlen  <= sa_zlen;
      sb_den   <= sa_den;
      sb_ax    <= sa_ax;
      sb_ks    <= sf3d_pkg::KS_W'(spring_constant) * sf3d_pkg::KS_W'(sa_astr);
    end
  end

  // Stage C: the wide product k*stretch*|d| as two partial products per axis.
  logic                        sc_valid;
  logic                        sc_sneg;
  logic                        sc_zlen;
  logic [sf3d_pkg::DEN_W-1:0]  sc_den;
  logic [2:0]                  sc_dneg;
  logic [sf3d_pkg::PLO_W-1:0]  sc_plo [3];
  logic [sf3d_pkg::PHI_W-1:0]  sc_phi [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else if (adv) begin
      sc_valid <= sb_valid;
      sc_sneg  <= sb_sneg;
      sc_zlen  <= sb_zlen;
      sc_den   <= sb_den;
      sc_dneg  <= sb_ax.dneg;
      for (int i = 0; i < 3; i++) begin
        sc_plo[i] <= sf3d_pkg::PLO_W'(sb_ks[sf3d_pkg::KS_LO_W-1:0])
                   * sf3d_pkg::PLO_W'(sb_ax.ad[i]);
        sc_phi[i] <= sf3d_pkg::PHI_W'(sb_ks[sf3d_pkg::KS_W-1:sf3d_pkg::KS_LO_W])
                   * sf3d_pkg::PHI_W'(sb_ax.ad[i]);
      end
    end
  end

  // Stage D: partial products summed into the numerator.
  logic                        sd_valid;
  logic                        sd_sneg;
  logic                        sd_zlen;
  logic [sf3d_pkg::DEN_W-1:0]  sd_den;
  logic [2:0]                  sd_dneg;
  logic [sf3d_pkg::N_W-1:0]    sd_num [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_valid <= 1'b0;
    end else if (adv) begin
      sd_valid <= sc_valid;
      sd_sneg  <= sc_sneg;
      sd_zlen  <= sc_zlen;
      sd_den   <= sc_den;
      sd_dneg  <= sc_dneg;
      for (int i = 0; i < 3; i++) begin
        sd_num[i] <= sf3d_pkg::N_W'(sc_plo[i])
                   + (sf3d_pkg::N_W'(sc_phi[i]) << sf3d_pkg::KS_LO_W);
      end
    end
  end

  // Stage E: a numerator whose upper part already reaches the divisor has a
  // quotient of at least 2^33 and saturates; otherwise the division rows
  // produce the remaining quotient bits.
  sf3d_pkg::div_stage_t dv   [3][sf3d_pkg::Q_W+1];
  sf3d_pkg::div_side_t  side [sf3d_pkg::Q_W+1];
  logic [sf3d_pkg::NHI_W-1:0] nhi [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nhi[i] = sd_num[i][sf3d_pkg::N_W-1:sf3d_pkg::Q_W];
    end
  end

  // The sign, saturation and zero-length flags travel beside the rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= sf3d_pkg::Q_W; k++) begin
        side[k].valid <= 1'b0;
      end
    end else if (adv) begin
      side[0].valid <= sd_valid;
      side[0].zlen  <= sd_zlen;
      for (int i = 0; i < 3; i++) begin
        // The force is negative when stretch and difference share a sign.
        side[0].neg[i]    <= (sd_sneg == sd_dneg[i]);
        side[0].presat[i] <= (nhi[i] >= sf3d_pkg::NHI_W'(sd_den));
      end
      for (int k = 0; k < sf3d_pkg::Q_W; k++) begin
        side[k+1] <= side[k];
      end
    end
  end

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[ax][0].rem  <= nhi[ax][sf3d_pkg::DEN_W-1:0];
        dv[ax][0].nlow <= sd_num[ax][sf3d_pkg::Q_W-1:0];
        dv[ax][0].quo  <= '0;
        dv[ax][0].den  <= sd_den;
      end
    end

    for (genvar g = 0; g < sf3d_pkg::Q_W; g++) begin : g_div
      sf3d_div_cell u_cell (
        .clk (clk),
        .en  (adv),
        .a   (dv[ax][g]),
        .y   (dv[ax][g+1])
      );
    end
  end

  // Output: clip, apply sign, and clear everything for a zero length.
  logic [sf3d_pkg::Q_W-1:0]   limit [3];
  logic [sf3d_pkg::Q_W-1:0]   mag   [3];
  logic                       over  [3];
  logic [sf3d_pkg::POS_W-1:0] frc   [3];
  logic                       sat_any;
  sf3d_pkg::div_side_t        tail;

  assign tail = side[sf3d_pkg::Q_W];

  always_comb begin
    sat_any = 1'b0;
    for (int i = 0; i < 3; i++) begin
      limit[i] = tail.neg[i] ? sf3d_pkg::Q_W'(33'h080000000)
                             : sf3d_pkg::Q_W'(33'h07fffffff);
      over[i]  = tail.presat[i] || (dv[i][sf3d_pkg::Q_W].quo > limit[i]);
      mag[i]   = over[i] ? limit[i] : dv[i][sf3d_pkg::Q_W].quo;
      frc[i]   = tail.neg[i] ? sf3d_pkg::POS_W'(-mag[i]) : sf3d_pkg::POS_W'(mag[i]);
      sat_any  = sat_any | over[i];
      if (tail.zlen) begin
        frc[i] = '0;
      end
    end
    if (tail.zlen) begin
      sat_any = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid     <= tail.valid;
      rsp.force_x   <= frc[0];
      rsp.force_y   <= frc[1];
      rsp.force_z   <= frc[2];
      rsp.saturated <= sat_any;
    end
  end

  // A clipped result carries at least one component at a range end.
  logic rsp_at_limit;
  logic rsp_all_zero;

  assign rsp_at_limit = rsp.force_x == 32'h7fffffff || rsp.force_x == 32'h80000000
                     || rsp.force_y == 32'h7fffffff || rsp.force_y == 32'h80000000
                     || rsp.force_z == 32'h7fffffff || rsp.force_z == 32'h80000000;
  assign rsp_all_zero = rsp.force_x == '0 && rsp.force_y == '0 && rsp.force_z == '0
                     && !rsp.saturated;

  `SF_ASSERT_NXT(a_accept_enters, clk, rst, req.valid && req.ready, s0_valid)
  `SF_ASSERT_NXT(a_stall_holds, clk, rst, !adv, $stable(sa_valid) && $stable(tail.valid))
  `SF_ASSERT_IMP(a_sat_at_limit, clk, rst, rsp.valid && rsp.saturated, rsp_at_limit)
  `SF_ASSERT_NXT(a_zero_len, clk, rst, adv && tail.valid && tail.zlen, rsp_all_zero)

endmodule
